// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default sizing, used as parameter defaults by the top level and submodules
  localparam int CAPACITY_DEF  = 16;
  localparam int TAG_WIDTH_DEF = 16;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_EXTRACT = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // Request payload
  typedef struct packed {
    op_t         op;
    logic [7:0]  priority_req;
    logic [15:0] data_in;
  } in_req_t;

  // Result payload
  typedef struct packed {
    status_t     status;
    logic [7:0]  priority_out;
    logic [15:0] data_out;
    logic [4:0]  occupancy;
  } out_rsp_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture request and cell compare flags
    logic exec;  // apply shift, register result
  } spq_cmd_t;

endpackage

// ----- src/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of register cells.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  request   start, busy, in_req         taken when start & !busy
//  result    out_valid, out_rsp          one-cycle strobe, always taken
//
// Each request runs in order: the accept edge captures the request along
// with every cell's compare flag, then the execute state shifts the cells
// and registers the result, which shows for one cycle while busy is already
// low again. No new request is taken while busy is high in execute.
// Synchronous reset empties the queue at once. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::in_req_t  in_req,
  output logic              out_valid,
  output spq_pkg::out_rsp_t out_rsp
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  spq_datapath #(
    .CAPACITY  (CAPACITY),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

endmodule

// ----- src/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Two-state sequencer: accepts a request, then runs the execute state.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output spq_pkg::spq_cmd_t cmd,
  output logic              out_valid
);
  import spq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  // State and result strobe registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    unique case (state_r)
      S_IDLE: cmd.load = start;
      S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted entry cells with per-cell compare flags and neighbor shifts.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::spq_cmd_t cmd,
  input  spq_pkg::in_req_t  in_req,
  output spq_pkg::out_rsp_t out_rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [7:0]           prio_r [CAPACITY];
  logic [TAG_WIDTH-1:0] tag_r  [CAPACITY];
  logic [CW-1:0]        count_r;
  logic [CAPACITY-1:0]  flag_r;
  op_t                  op_r;
  logic [7:0]           req_prio_r;
  logic [TAG_WIDTH-1:0] req_tag_r;
  out_rsp_t             rsp_r;

  logic [CAPACITY-1:0]  flag_nxt;
  logic [CAPACITY-1:0]  prev_flag;
  logic [CAPACITY-1:0]  hit;
  logic                 found;
  logic                 full;
  logic [7:0]           sel_prio;
  logic [TAG_WIDTH-1:0] sel_tag;
  out_rsp_t             rsp_nxt;

  // Cell flags: set at and after the insert / match point (empty cells set too).
  // The row is sorted, so the flags form a thermometer.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      logic cmp;
      cmp = 1'b1;
      unique case (in_req.op)
        OP_PUSH:    cmp = (prio_r[i] > in_req.priority_req);
        OP_POP:     cmp = 1'b1;
        OP_EXTRACT: cmp = (prio_r[i] >= in_req.priority_req);
        default:    cmp = 1'b1;
      endcase
      flag_nxt[i] = (CW'(i) >= count_r) || cmp;
    end
  end

  // Leading edge of the thermometer, restricted to held entries
  assign prev_flag = {flag_r[CAPACITY-2:0], 1'b0};
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = flag_r[i] & ~prev_flag[i] & (CW'(i) < count_r);
    end
  end
  assign found = |hit;
  assign full  = (count_r == CW'(CAPACITY));

  // One-hot selection of the removed entry
  always_comb begin
    sel_prio = '0;
    sel_tag  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_prio = sel_prio | (prio_r[i] & {8{hit[i]}});
      sel_tag  = sel_tag  | (tag_r[i]  & {TAG_WIDTH{hit[i]}});
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flag_r     <= flag_nxt;
      op_r       <= in_req.op;
      req_prio_r <= in_req.priority_req;
      req_tag_r  <= TAG_WIDTH'(in_req.data_in);
    end
  end

  // Entry cells: insert shifts toward the back, removal toward the front
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0]           up_prio, dn_prio;
    logic [TAG_WIDTH-1:0] up_tag,  dn_tag;
    if (g == 0) begin : g_first
      assign up_prio = req_prio_r;
      assign up_tag  = req_tag_r;
    end else begin : g_mid
      assign up_prio = prio_r[g-1];
      assign up_tag  = tag_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign dn_prio = prio_r[g];
      assign dn_tag  = tag_r[g];
    end else begin : g_rest
      assign dn_prio = prio_r[g+1];
      assign dn_tag  = tag_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        unique case (op_r)
          OP_PUSH: if (!full && flag_r[g]) begin
            if (!prev_flag[g]) begin
              prio_r[g] <= req_prio_r;
              tag_r[g]  <= req_tag_r;
            end else begin
              prio_r[g] <= up_prio;
              tag_r[g]  <= up_tag;
            end
          end
          OP_POP, OP_EXTRACT: if (found && flag_r[g]) begin
            prio_r[g] <= dn_prio;
            tag_r[g]  <= dn_tag;
          end
          default: ;
        endcase
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      unique case (op_r)
        OP_PUSH:            if (!full) count_r <= count_r + CW'(1);
        OP_POP, OP_EXTRACT: if (found) count_r <= count_r - CW'(1);
        default: ;
      endcase
    end
  end

  // Result of the operation in execute
  always_comb begin
    rsp_nxt.status       = ST_DONE;
    rsp_nxt.priority_out = '0;
    rsp_nxt.data_out     = '0;
    rsp_nxt.occupancy    = 5'(count_r);
    unique case (op_r)
      OP_PUSH: begin
        if (full) rsp_nxt.status = ST_FULL;
        else      rsp_nxt.occupancy = 5'(count_r + CW'(1));
      end
      OP_POP, OP_EXTRACT: begin
        if (found) begin
          rsp_nxt.priority_out = sel_prio;
          rsp_nxt.data_out     = 16'(sel_tag);
          rsp_nxt.occupancy    = 5'(count_r - CW'(1));
        end else begin
          rsp_nxt.status = ST_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp = rsp_r;

endmodule

// ----- src/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on request timing and result consistency.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input spq_pkg::out_rsp_t out_rsp
);
  import spq_pkg::*;

  // Every accepted request yields a result once the execute state has passed
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after request");

  // Results never come in consecutive cycles
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Accept moves the block to busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A dropped push reports a full queue
  a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ST_FULL) |-> (out_rsp.occupancy == 5'(CAPACITY)))
    else $error("push dropped while queue not full");

  // A miss carries no entry
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ST_NONE) |->
      (out_rsp.priority_out == 8'd0 && out_rsp.data_out == 16'd0))
    else $error("miss result carries entry data");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
